/* sv/tkss_pkg.sv */
// tkss_pkg: shared types and constants of the top-k smallest selector
// no dependencies; used by the interfaces, the cell and the top level

package tkss_pkg;

   localparam int unsigned IdWidth    = 31;
   localparam int unsigned ScoreWidth = 31;
   localparam int unsigned PosWidth   = 5;
   localparam int unsigned CsrWidth   = 6;
   localparam logic [CsrWidth-1:0] KResetValue = 6'd8;

   typedef logic [IdWidth-1:0]    id_type;
   typedef logic [ScoreWidth-1:0] score_type;

   // one list entry as held in a cell
   typedef struct packed {
      logic      valid;
      score_type score;
      id_type    id;
   } tkss_entry_type;

   // controls broadcast from the top level to every cell
   typedef struct packed {
      logic      insert;
      logic      shift;
      logic      clear;
      score_type new_score;
      id_type    new_id;
   } tkss_ctrl_type;

endpackage

/* sv/tkss_req_if.sv */
// tkss_req_if: input channel of the selector, valid/ready with one item per word
// depends on tkss_pkg

interface tkss_req_if import tkss_pkg::*; ();
   logic      valid;
   logic      ready;
   id_type    doc_id;
   score_type score;
   logic      batch_end;

   modport source (output valid, output doc_id, output score, output batch_end, input ready);
   modport sink   (input valid, input doc_id, input score, input batch_end, output ready);
endinterface

/* sv/tkss_rsp_if.sv */
// tkss_rsp_if: result channel of the selector, valid/ready with one rank per word
// depends on tkss_pkg

interface tkss_rsp_if import tkss_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [PosWidth-1:0] position;
   id_type              out_doc_id;
   logic                entry_valid;
   logic                run_end;

   modport source (output valid, output position, output out_doc_id, output entry_valid,
                   output run_end, input ready);
   modport sink   (input valid, input position, input out_doc_id, input entry_valid,
                   input run_end, output ready);
endinterface

/* sv/tkss_cell.sv */
// tkss_cell: one slot of the sorted insertion chain
// depends on tkss_pkg; instanced in a row by the top level

module tkss_cell import tkss_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  tkss_ctrl_type  ctrl,
   input  logic           in_range,
   input  logic           left_ins,
   input  tkss_entry_type left_entry,
   input  tkss_entry_type right_entry,
   output logic           ins,
   output tkss_entry_type entry
);

   tkss_entry_type entry_ff, entry_in;

   // new item goes at or before this slot (strictly greater keeps ties stable)
   assign ins   = !entry_ff.valid || (entry_ff.score > ctrl.new_score);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.clear) begin
         entry_in.valid = 1'b0;
      end else if (ctrl.insert) begin
         if (ins && left_ins) begin
            entry_in = left_entry;
         end else if (ins) begin
            entry_in.valid = 1'b1;
            entry_in.score = ctrl.new_score;
            entry_in.id    = ctrl.new_id;
         end
         entry_in.valid = entry_in.valid && in_range;
      end else if (ctrl.shift) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.score <= entry_in.score;
      entry_ff.id    <= entry_in.id;
   end

endmodule

/* sv/top_k_smallest_selector.sv */
// top_k_smallest_selector: top level, chain of insertion cells plus drain control
// depends on tkss_pkg, tkss_req_if, tkss_rsp_if and tkss_cell

// Keeps the k smallest-scored (doc_id, score) words of a batch in a row of MAX_K
// cells sorted by ascending score; equal scores keep arrival order. Every cell
// compares its score with the incoming one in the same cycle, so one input word
// is taken per clock while a batch is filling. The word marked batch_end is
// inserted like any other, then the row drains through cell 0 into the output
// register: k result words, one per cycle when the sink keeps ready high, with
// the input held off. Ranks that no item filled come out with entry_valid 0
// and out_doc_id 0. k comes from the csr register (reset 8); 0 reads as 1 and
// values above MAX_K saturate. Write it only between batches or while the list
// may be cut.

module top_k_smallest_selector import tkss_pkg::*; #(
   parameter int unsigned MAX_K = 32
) (
   input  logic                clock,
   input  logic                reset,
   tkss_req_if.sink            req_chan,
   tkss_rsp_if.source          rsp_chan,
   input  logic                csr_we,
   input  logic [CsrWidth-1:0] csr_wdata
);

   localparam int unsigned KW = $clog2(MAX_K + 1);

   typedef enum logic {
      ST_FILL,
      ST_DRAIN
   } state_type;

   // k register and its clamped value
   logic [CsrWidth-1:0] csr_k_ff;
   logic [KW-1:0]       k_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_k_ff <= KResetValue;
      end else if (csr_we) begin
         csr_k_ff <= csr_wdata;
      end
   end

   always_comb begin
      if (csr_k_ff == '0) begin
         k_eff = KW'(1);
      end else if (int'(csr_k_ff) > int'(MAX_K)) begin
         k_eff = KW'(MAX_K);
      end else begin
         k_eff = KW'(csr_k_ff);
      end
   end

   // control state and output register
   state_type           state_ff, state_in;
   logic [KW-1:0]       cnt_ff, cnt_in;
   logic [KW-1:0]       klat_ff, klat_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PosWidth-1:0] pos_ff, pos_in;
   id_type              rsp_id_ff, rsp_id_in;
   logic                rsp_ev_ff, rsp_ev_in;
   logic                rsp_end_ff, rsp_end_in;

   logic           take_item;
   logic           load_word;
   logic           last_word;
   tkss_ctrl_type  ctrl;
   tkss_entry_type entries [MAX_K];
   logic           ins_vec [MAX_K];

   assign req_chan.ready = (state_ff == ST_FILL);
   assign take_item      = req_chan.valid && req_chan.ready;

   // during the drain, a word moves out of cell 0 whenever the output register is free or emptying
   assign load_word = (state_ff == ST_DRAIN) && (!rsp_valid_ff || rsp_chan.ready);
   assign last_word = (cnt_ff == klat_ff - KW'(1));

   assign ctrl.insert    = take_item;
   assign ctrl.shift     = load_word && !last_word;
   assign ctrl.clear     = load_word && last_word;
   assign ctrl.new_score = req_chan.score;
   assign ctrl.new_id    = req_chan.doc_id;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      klat_in      = klat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      pos_in       = pos_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_ev_in    = rsp_ev_ff;
      rsp_end_in   = rsp_end_ff;
      case (state_ff)
         ST_FILL: begin
            if (take_item && req_chan.batch_end) begin
               state_in = ST_DRAIN;
               cnt_in   = '0;
               klat_in  = k_eff;
            end
         end
         ST_DRAIN: begin
            if (load_word) begin
               rsp_valid_in = 1'b1;
               pos_in       = PosWidth'(cnt_ff);
               rsp_ev_in    = entries[0].valid;
               rsp_id_in    = entries[0].valid ? entries[0].id : '0;
               rsp_end_in   = last_word;
               cnt_in       = cnt_ff + KW'(1);
               if (last_word) begin
                  state_in = ST_FILL;
               end
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         cnt_ff       <= '0;
         klat_ff      <= KW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         klat_ff      <= klat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff     <= pos_in;
      rsp_id_ff  <= rsp_id_in;
      rsp_ev_ff  <= rsp_ev_in;
      rsp_end_ff <= rsp_end_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.position    = pos_ff;
   assign rsp_chan.out_doc_id  = rsp_id_ff;
   assign rsp_chan.entry_valid = rsp_ev_ff;
   assign rsp_chan.run_end     = rsp_end_ff;

   // the row of cells: left neighbor feeds inserts, right neighbor feeds the drain
   localparam tkss_entry_type EmptyEntry = '0;

   for (genvar i = 0; i < MAX_K; i++) begin : g_cell
      logic           left_ins;
      tkss_entry_type left_entry;
      tkss_entry_type right_entry;

      if (i == 0) begin : g_head
         assign left_ins   = 1'b0;
         assign left_entry = EmptyEntry;
      end else begin : g_body
         assign left_ins   = ins_vec[i-1];
         assign left_entry = entries[i-1];
      end

      if (i == MAX_K - 1) begin : g_tail
         assign right_entry = EmptyEntry;
      end else begin : g_inner
         assign right_entry = entries[i+1];
      end

      tkss_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .in_range    (KW'(i) < k_eff),
         .left_ins    (left_ins),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .ins         (ins_vec[i]),
         .entry       (entries[i])
      );
   end

endmodule

/* sv/tkss_checker.sv */
// tkss_checker: port-level checks of the selector, attached by bind
// depends on tkss_pkg and top_k_smallest_selector

module tkss_checker import tkss_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [PosWidth-1:0] rsp_position,
   input id_type              rsp_doc_id,
   input logic                rsp_entry_valid,
   input logic                rsp_run_end
);

   // stalled result word keeps its content
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_doc_id) &&
                                  $stable(rsp_position) && $stable(rsp_run_end))
      else $error("result word changed while stalled");

   // unfilled rank carries a zero id
   a_empty_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_entry_valid |-> rsp_doc_id == '0)
      else $error("invalid rank with nonzero id");

   // input is held off until the run has fully left the chain
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_end |-> !req_ready)
      else $error("input taken in the middle of a run");

   // filled ranks come first: after an empty rank no filled one follows
   a_prefix: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_entry_valid && !rsp_run_end
      |=> !(rsp_valid && rsp_entry_valid))
      else $error("filled rank after an empty one");

endmodule

bind top_k_smallest_selector tkss_checker u_tkss_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_position    (rsp_chan.position),
   .rsp_doc_id      (rsp_chan.out_doc_id),
   .rsp_entry_valid (rsp_chan.entry_valid),
   .rsp_run_end     (rsp_chan.run_end)
);
